[hdl/kei_pkg.sv]
package kei_pkg;

  localparam int unsigned CHANNELS_DEF = 8;
  localparam int unsigned KEYS_DEF     = 32;

  localparam logic [1:0] ACT_SET   = 2'd0;
  localparam logic [1:0] ACT_DEL   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic [1:0] EASE_LIN  = 2'd0;
  localparam logic [1:0] EASE_SINE = 2'd1;
  localparam logic [1:0] EASE_OUT  = 2'd2;
  localparam logic [1:0] EASE_IN   = 2'd3;

  // Odd polynomial for sin(pi/2 * u) in Q2.30, Horner order after the top term.
  localparam logic [31:0] SC9 = 32'd172273;
  localparam logic [31:0] HORNER_C [4] = '{32'd5026995, 32'd85569306, 32'd693598668,
                                            32'd1686629713};

  typedef struct packed {
    logic [1:0]         action;
    logic [2:0]         channel;
    logic [15:0]        frame;
    logic [1:0]         ease_mode;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
  } kei_in_t;

  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;
    logic [1:0]         status;
  } kei_out_t;

  typedef struct packed {
    logic [15:0]        frame;
    logic [1:0]         mode;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } key_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_UPD,
    CELL_DEL
  } cell_op_e;

  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } cell_flags_t;

  typedef struct packed {
    logic        any_eq;
    logic        full;
    logic        empty;
    logic        nx_found;
    logic [15:0] lo;
    logic [15:0] hi;
  } row_stat_t;

endpackage

[hdl/kei_cell.sv]
module kei_cell import kei_pkg::*; (
  input  logic        clk_i,
  input  cell_op_e    op_i,
  input  logic [15:0] f_i,
  input  logic        valid_i,
  input  logic        lt_left_i,
  input  key_t        left_i,
  input  key_t        right_i,
  input  key_t        din_i,
  output key_t        key_o,
  output cell_flags_t flags_o
);

  key_t key_q, key_d;

  assign flags_o.lt = valid_i && (key_q.frame < f_i);
  assign flags_o.eq = valid_i && (key_q.frame == f_i);
  assign flags_o.gt = valid_i && (key_q.frame > f_i);
  assign key_o      = key_q;

  always_comb begin
    key_d = key_q;
    unique case (op_i)
      CELL_HOLD: key_d = key_q;
      CELL_UPD: begin
        if (flags_o.eq) key_d = din_i;
      end
      CELL_INS: begin
        // The first cell not below the new frame takes it; the rest move right.
        if (!flags_o.lt) key_d = lt_left_i ? din_i : left_i;
      end
      CELL_DEL: begin
        if (!flags_o.lt) key_d = right_i;
      end
      default: key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

[hdl/kei_row.sv]
module kei_row import kei_pkg::*; #(
  parameter int unsigned KEYS = KEYS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  cell_op_e  op_i,
  input  logic [15:0] f_i,
  input  key_t      din_i,
  output row_stat_t stat_o,
  output key_t      st_o,
  output key_t      nx_o
);

  localparam int unsigned CNT_W = $clog2(KEYS + 1);

  logic [CNT_W-1:0] count_q, count_d;
  cell_op_e         cell_op;
  key_t             keys  [KEYS];
  cell_flags_t      flags [KEYS];
  logic [KEYS-1:0]  valid, st_hit, nx_hit, last_hit;

  assign cell_op = en_i ? op_i : CELL_HOLD;

  for (genvar k = 0; k < KEYS; k++) begin : g_cell
    assign valid[k] = CNT_W'(k) < count_q;
    kei_cell u_cell (
      .clk_i     (clk_i),
      .op_i      (cell_op),
      .f_i       (f_i),
      .valid_i   (valid[k]),
      .lt_left_i ((k == 0) ? 1'b1 : flags[(k == 0) ? 0 : k-1].lt),
      .left_i    (keys[(k == 0) ? 0 : k-1]),
      .right_i   (keys[(k == KEYS-1) ? k : k+1]),
      .din_i     (din_i),
      .key_o     (keys[k]),
      .flags_o   (flags[k])
    );
    if (k == KEYS-1) begin : g_end
      assign st_hit[k]   = valid[k] && !flags[k].gt;
      assign last_hit[k] = valid[k];
    end else begin : g_mid
      assign st_hit[k]   = valid[k] && !flags[k].gt && !(valid[k+1] && !flags[k+1].gt);
      assign last_hit[k] = valid[k] && !valid[k+1];
    end
    if (k == 0) begin : g_first
      assign nx_hit[k] = flags[k].gt;
    end else begin : g_next
      assign nx_hit[k] = flags[k].gt && !flags[k-1].gt;
    end
  end

  always_comb begin
    stat_o          = '0;
    st_o            = '0;
    nx_o            = '0;
    stat_o.full     = count_q == CNT_W'(KEYS);
    stat_o.empty    = count_q == '0;
    stat_o.lo       = keys[0].frame;
    for (int k = 0; k < KEYS; k++) begin
      stat_o.any_eq   = stat_o.any_eq | flags[k].eq;
      stat_o.nx_found = stat_o.nx_found | nx_hit[k];
      stat_o.hi       = stat_o.hi | (keys[k].frame & {16{last_hit[k]}});
      st_o            = st_o | (keys[k] & {$bits(key_t){st_hit[k]}});
      nx_o            = nx_o | (keys[k] & {$bits(key_t){nx_hit[k]}});
    end
  end

  always_comb begin
    count_d = count_q;
    if (cell_op == CELL_INS) count_d = count_q + 1'b1;
    else if (cell_op == CELL_DEL) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

[hdl/keyframe_eased_interpolator_top.sv]
// Channel  Direction  Handshake                  Payload
// command  in         start / busy               cmd_i (kei_in_t)
// result   out        done_o, one-cycle strobe   res_o (kei_out_t)
//
// Set, delete, no-op and empty-channel query transactions go from lookup to the output state;
// busy falls in the cycle after the result strobe, and the next transaction can go in then.
// A query at or past the last key goes lookup, select, output; any other query goes lookup,
// select, bit-serial divider for t, shared Horner multiplier, easing, blend (each component
// in turn) and the output state.
// Keys live in a chain of cells per channel; reset clears the key counts only.
// busy stays high from acceptance through the result strobe; the receiver cannot stall.
module keyframe_eased_interpolator_top import kei_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF,
  parameter int unsigned KEYS     = KEYS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  kei_in_t  cmd_i,
  output logic     done_o,
  output kei_out_t res_o
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CHX_W = 7;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_SEL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_POLY  = 3'd4;
  localparam logic [2:0] S_EASE  = 3'd5;
  localparam logic [2:0] S_BLEND = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  kei_in_t     cmd_q, cmd_d;
  kei_out_t    res_q, res_d;
  logic [15:0] fq_q, fq_d, diff_q, diff_d, t_q, t_d;
  logic [16:0] rem_q, rem_d, u_q, u_d, s_q, s_d, w_q, w_d;
  logic [30:0] u2_q, u2_d;
  logic [31:0] p_q, p_d;
  logic [1:0]  mode_q, mode_d;
  key_t        a_q, a_d, b_q, b_d;

  logic [CHX_W-1:0] ch_ext;
  logic             ch_ok;
  logic [CH_W-1:0]  ch_idx;
  cell_op_e         row_op;
  logic [15:0]      f_cmp;
  key_t             din;
  row_stat_t        stats [2**CH_W];
  key_t             sts   [2**CH_W];
  key_t             nxs   [2**CH_W];
  row_stat_t        rs;
  key_t             st_k, nx_k;

  logic [17:0] rem2;
  logic [33:0] uu, ss;
  logic [62:0] hprod;
  logic [48:0] sp;
  logic [33:0] s_rnd;
  logic [34:0] ss_rnd;
  logic signed [31:0] sa, sb;
  logic signed [32:0] dd;
  logic signed [50:0] bprod, bprod_rnd;
  logic signed [34:0] r_wide;

  assign ch_ext = CHX_W'(cmd_q.channel);
  assign ch_ok  = ch_ext < CHX_W'(CHANNELS);
  assign ch_idx = ch_ext[CH_W-1:0];
  assign f_cmp  = (state_q == S_SEL) ? fq_q : cmd_q.frame;
  assign rs     = stats[ch_idx];
  assign st_k   = sts[ch_idx];
  assign nx_k   = nxs[ch_idx];

  always_comb begin
    din.frame = cmd_q.frame;
    din.mode  = cmd_q.ease_mode;
    din.vx    = cmd_q.value_x;
    din.vy    = cmd_q.value_y;
    din.vz    = cmd_q.value_z;
  end

  for (genvar c = 0; c < 2**CH_W; c++) begin : g_row
    if (c < CHANNELS) begin : g_live
      kei_row #(.KEYS(KEYS)) u_row (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (ch_ok && (ch_idx == CH_W'(c))),
        .op_i   (row_op),
        .f_i    (f_cmp),
        .din_i  (din),
        .stat_o (stats[c]),
        .st_o   (sts[c]),
        .nx_o   (nxs[c])
      );
    end else begin : g_none
      assign stats[c] = '0;
      assign sts[c]   = '0;
      assign nxs[c]   = '0;
    end
  end

  always_comb begin
    row_op = CELL_HOLD;
    if (state_q == S_LOOK && ch_ok) begin
      unique case (cmd_q.action)
        ACT_SET: row_op = rs.any_eq ? CELL_UPD : (rs.full ? CELL_HOLD : CELL_INS);
        ACT_DEL: row_op = rs.any_eq ? CELL_DEL : CELL_HOLD;
        default: row_op = CELL_HOLD;
      endcase
    end
  end

  // Shared arithmetic for the current step.
  assign rem2   = {rem_q, 1'b0};
  assign uu     = u_q * u_q;
  assign hprod  = u2_q * p_q;
  assign sp     = u_q * p_q;
  assign s_rnd  = {1'b0, sp[48:16]} + 34'd8192;
  assign ss     = s_q * s_q;
  assign ss_rnd = {1'b0, ss} + 35'd32768;

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    begin sa = a_q.vx; sb = b_q.vx; end
      2'd1:    begin sa = a_q.vy; sb = b_q.vy; end
      default: begin sa = a_q.vz; sb = b_q.vz; end
    endcase
    dd        = 33'(sb) - 33'(sa);
    bprod     = 51'(dd) * 51'($signed({1'b0, w_q}));
    bprod_rnd = (bprod + 51'sd32768) >>> 16;
    r_wide    = 35'(sa) + bprod_rnd[34:0];
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_d   = cmd_q;
    res_d   = res_q;
    fq_d    = fq_q;
    diff_d  = diff_q;
    t_d     = t_q;
    rem_d   = rem_q;
    u_d     = u_q;
    u2_d    = u2_q;
    p_d     = p_q;
    s_d     = s_q;
    w_d     = w_q;
    mode_d  = mode_q;
    a_d     = a_q;
    b_d     = b_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d   = cmd_i;
          res_d   = '0;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_OUT;
        unique case (cmd_q.action)
          ACT_SET: begin
            if (ch_ok && !rs.any_eq && rs.full) res_d.status = STAT_FULL;
          end
          ACT_QUERY: begin
            if (!ch_ok || rs.empty) begin
              res_d.status = STAT_EMPTY;
            end else begin
              if (cmd_q.frame < rs.lo) fq_d = rs.lo;
              else if (cmd_q.frame > rs.hi) fq_d = rs.hi;
              else fq_d = cmd_q.frame;
              state_d = S_SEL;
            end
          end
          default: state_d = S_OUT;
        endcase
      end
      S_SEL: begin
        a_d    = st_k;
        b_d    = nx_k;
        mode_d = nx_k.mode;
        if (!rs.nx_found) begin
          res_d.result_x = st_k.vx;
          res_d.result_y = st_k.vy;
          res_d.result_z = st_k.vz;
          state_d        = S_OUT;
        end else begin
          rem_d   = {1'b0, fq_q - st_k.frame};
          diff_d  = nx_k.frame - st_k.frame;
          t_d     = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (rem2 >= {2'b00, diff_q}) begin
          rem_d = 17'(rem2 - {2'b00, diff_q});
          t_d   = {t_q[14:0], 1'b1};
        end else begin
          rem_d = rem2[16:0];
          t_d   = {t_q[14:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'd15) begin
          u_d     = (mode_q == EASE_IN) ? 17'd65536 - {1'b0, t_d} : {1'b0, t_d};
          cnt_d   = '0;
          state_d = S_POLY;
        end
      end
      S_POLY: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'd0) begin
          u2_d = uu[32:2];
          p_d  = SC9;
        end else if (cnt_q < 5'd5) begin
          p_d = HORNER_C[cnt_q[1:0] - 2'd1] - hprod[61:30];
        end else begin
          s_d     = (s_rnd[33:14] > 20'd65536) ? 17'd65536 : s_rnd[30:14];
          state_d = S_EASE;
        end
      end
      S_EASE: begin
        unique case (mode_q)
          EASE_LIN:  w_d = {1'b0, t_q};
          EASE_SINE: w_d = ss_rnd[32:16];
          EASE_OUT:  w_d = s_q;
          default:   w_d = 17'd65536 - s_q;
        endcase
        cnt_d   = '0;
        state_d = S_BLEND;
      end
      S_BLEND: begin
        unique case (cnt_q[1:0])
          2'd0:    res_d.result_x = r_wide[31:0];
          2'd1:    res_d.result_y = r_wide[31:0];
          default: res_d.result_z = r_wide[31:0];
        endcase
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'd2) state_d = S_OUT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    res_q  <= res_d;
    fq_q   <= fq_d;
    diff_q <= diff_d;
    t_q    <= t_d;
    rem_q  <= rem_d;
    u_q    <= u_d;
    u2_q   <= u2_d;
    p_q    <= p_d;
    s_q    <= s_d;
    w_q    <= w_d;
    mode_q <= mode_d;
    a_q    <= a_d;
    b_q    <= b_d;
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = state_q == S_OUT;
  assign res_o  = res_q;

endmodule

[hdl/kei_checker.sv]
module kei_checker import kei_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy_i,
  input logic     done_i,
  input kei_out_t res_i
);

  // An accepted transaction holds the block busy until its result.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy_i) |=> busy_i) else $error("accept did not raise busy");

  // The result strobe comes while busy and releases the block right after.
  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> (busy_i ##1 !busy_i && !done_i)) else $error("done did not release busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> (res_i.status == STAT_OK || res_i.status == STAT_FULL ||
                res_i.status == STAT_EMPTY)) else $error("bad status code");

  // A flagged transaction carries a zero value.
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && res_i.status != STAT_OK) |->
      (res_i.result_x == 0 && res_i.result_y == 0 && res_i.result_z == 0))
    else $error("flagged result is not zero");

endmodule

bind keyframe_eased_interpolator_top kei_checker u_kei_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy_i (busy),
  .done_i (done_o),
  .res_i  (res_o)
);

[test/keyframe_eased_interpolator_checker.sv]
`timescale 1ns / 100ps

module keyframe_eased_interpolator_checker import kei_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     busy,
  input  kei_in_t  cmd_i,
  input  logic     done_o,
  input  kei_out_t res_o,
  output int       fail_count,
  output int       pending_count,
  output int       query_count
);

  localparam int NCH  = CHANNELS_DEF;
  localparam int NKEY = KEYS_DEF;

  key_t     table_keys [NCH][NKEY];
  int       table_len [NCH] = '{default: 0};
  kei_out_t answer_q [$];
  int       fails = 0;
  int       queries = 0;

  assign fail_count  = fails;
  assign query_count = queries;

  // sin(pi/2 * u) with u in Q1.16, evaluated in Q2.30.
  function automatic logic [31:0] quarter_sine(input logic [31:0] u);
    logic [63:0] uq, u2, p, s;
    uq = {32'd0, u} << 14;
    u2 = (uq * uq) >> 30;
    p  = 64'd172273;
    p  = 64'd5026995    - ((u2 * p) >> 30);
    p  = 64'd85569306   - ((u2 * p) >> 30);
    p  = 64'd693598668  - ((u2 * p) >> 30);
    p  = 64'd1686629713 - ((u2 * p) >> 30);
    s  = (uq * p) >> 30;
    s  = (s + 64'd8192) >> 14;
    if (s > 64'd65536) s = 64'd65536;
    return s[31:0];
  endfunction

  function automatic logic [31:0] eased_weight(input logic [1:0] mode, input logic [31:0] t);
    logic [63:0] s;
    case (mode)
      EASE_SINE: begin
        s = {32'd0, quarter_sine(t)};
        return 32'((s * s + 64'd32768) >> 16);
      end
      EASE_OUT: return quarter_sine(t);
      EASE_IN:  return 32'd65536 - quarter_sine(32'd65536 - t);
      default:  return t;
    endcase
  endfunction

  function automatic logic signed [31:0] mix(input logic signed [31:0] a,
                                             input logic signed [31:0] b,
                                             input logic [31:0] w);
    longint d, prod;
    d    = longint'(b) - longint'(a);
    prod = d * longint'(w) + 64'sd32768;
    // Arithmetic shift floors, which gives round half up.
    return 32'(longint'(a) + (prod >>> 16));
  endfunction

  function automatic kei_out_t apply_command(input kei_in_t c);
    kei_out_t r;
    int n, i, j, nx, st;
    logic [15:0] f, fs;
    logic [31:0] t, w, diff;
    r = '0;
    n = table_len[c.channel];
    i = 0;
    while (i < n && table_keys[c.channel][i].frame < c.frame) i++;
    case (c.action)
      ACT_SET: begin
        if (i < n && table_keys[c.channel][i].frame == c.frame) begin
          table_keys[c.channel][i] = '{c.frame, c.ease_mode, c.value_x, c.value_y, c.value_z};
        end else if (n >= NKEY) begin
          r.status = STAT_FULL;
        end else begin
          for (j = n; j > i; j--) table_keys[c.channel][j] = table_keys[c.channel][j-1];
          table_keys[c.channel][i] = '{c.frame, c.ease_mode, c.value_x, c.value_y, c.value_z};
          table_len[c.channel] = n + 1;
        end
      end
      ACT_DEL: begin
        if (i < n && table_keys[c.channel][i].frame == c.frame) begin
          for (j = i; j + 1 < n; j++) table_keys[c.channel][j] = table_keys[c.channel][j+1];
          table_len[c.channel] = n - 1;
        end
      end
      ACT_QUERY: begin
        if (n == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          f = c.frame;
          if (f < table_keys[c.channel][0].frame) f = table_keys[c.channel][0].frame;
          if (f > table_keys[c.channel][n-1].frame) f = table_keys[c.channel][n-1].frame;
          nx = 0;
          while (nx < n && table_keys[c.channel][nx].frame <= f) nx++;
          if (nx >= n) begin
            r.result_x = table_keys[c.channel][n-1].vx;
            r.result_y = table_keys[c.channel][n-1].vy;
            r.result_z = table_keys[c.channel][n-1].vz;
          end else begin
            st   = nx - 1;
            fs   = table_keys[c.channel][st].frame;
            diff = 32'(table_keys[c.channel][nx].frame) - 32'(fs);
            t    = ({16'd0, f - fs} << 16) / diff;
            w    = eased_weight(table_keys[c.channel][nx].mode, t);
            r.result_x = mix(table_keys[c.channel][st].vx, table_keys[c.channel][nx].vx, w);
            r.result_y = mix(table_keys[c.channel][st].vy, table_keys[c.channel][nx].vy, w);
            r.result_z = mix(table_keys[c.channel][st].vz, table_keys[c.channel][nx].vz, w);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    kei_out_t exp_r;
    if (rst_ni) begin
      if (done_o) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, res_o);
          fails++;
        end else begin
          exp_r = answer_q.pop_front();
          if (exp_r.result_x !== res_o.result_x) begin
            $display("%0t: result_x expected %h actual %h", $time, exp_r.result_x,
                     res_o.result_x);
            fails++;
          end
          if (exp_r.result_y !== res_o.result_y) begin
            $display("%0t: result_y expected %h actual %h", $time, exp_r.result_y,
                     res_o.result_y);
            fails++;
          end
          if (exp_r.result_z !== res_o.result_z) begin
            $display("%0t: result_z expected %h actual %h", $time, exp_r.result_z,
                     res_o.result_z);
            fails++;
          end
          if (exp_r.status !== res_o.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                     res_o.status);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        if (cmd_i.action == ACT_QUERY) queries++;
        answer_q.insert(answer_q.size(), apply_command(cmd_i));
      end
      pending_count = answer_q.size();
    end
  end

endmodule

[test/keyframe_eased_interpolator_top_tb.sv]
`timescale 1ns / 100ps

module keyframe_eased_interpolator_top_tb;
  import kei_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  kei_in_t  cmd_i = '0;
  logic     done_o;
  kei_out_t res_o;
  int       fail_count, pending_count, query_count;
  int       sent_count = 0;

  always #2 clk_i = ~clk_i;

  keyframe_eased_interpolator_top dut (.*);

  keyframe_eased_interpolator_checker u_checker (.*);

  // Raises start and waits on clock edges while busy is high; start stays high into the next
  // transaction when there is no gap.
  task automatic send_command(input kei_in_t c);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_i <= c;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    sent_count++;
  endtask

  function automatic kei_in_t make_cmd(input logic [1:0] act, input logic [2:0] ch,
                                       input logic [15:0] fr, input logic [1:0] md);
    kei_in_t c;
    c.action    = act;
    c.channel   = ch;
    c.frame     = fr;
    c.ease_mode = md;
    c.value_x   = $urandom;
    c.value_y   = $urandom;
    c.value_z   = $urandom;
    return c;
  endfunction

  function automatic logic [15:0] random_frame(input logic [2:0] ch);
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'h0000;
      default: return 16'(ch * 40 + $urandom_range(0, 40));
    endcase
  endfunction

  initial begin
    kei_in_t c;
    logic [2:0] ch;
    int r;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty channel, then a single key with extreme values.
    send_command(make_cmd(ACT_QUERY, 3'd0, 16'd5, EASE_LIN));
    c = make_cmd(ACT_SET, 3'd0, 16'd100, EASE_LIN);
    c.value_x = 32'sh7FFFFFFF; c.value_y = 32'sh80000000; c.value_z = 32'sh0;
    send_command(c);
    send_command(make_cmd(ACT_QUERY, 3'd0, 16'd0, EASE_LIN));
    send_command(make_cmd(ACT_QUERY, 3'd0, 16'hFFFF, EASE_LIN));
    c = make_cmd(ACT_SET, 3'd0, 16'hFFFF, EASE_SINE);
    c.value_x = 32'sh80000000; c.value_y = 32'sh7FFFFFFF; c.value_z = 32'shFFFFFFFF;
    send_command(c);
    c = make_cmd(ACT_SET, 3'd0, 16'd0, EASE_OUT);
    send_command(c);
    send_command(make_cmd(ACT_SET, 3'd0, 16'd100, EASE_IN));
    send_command(make_cmd(ACT_QUERY, 3'd0, 16'd50, EASE_LIN));
    send_command(make_cmd(ACT_QUERY, 3'd0, 16'd30000, EASE_LIN));
    send_command(make_cmd(ACT_QUERY, 3'd0, 16'hFFFE, EASE_LIN));
    send_command(make_cmd(ACT_DEL, 3'd0, 16'd7, EASE_LIN));
    send_command(make_cmd(ACT_DEL, 3'd0, 16'd100, EASE_LIN));
    send_command(make_cmd(ACT_QUERY, 3'd0, 16'd100, EASE_LIN));
    send_command(make_cmd(ACT_NOP, 3'd7, 16'hFFFF, EASE_IN));
    // Fill channel 7 past its capacity.
    for (int k = 0; k < KEYS_DEF + 2; k++)
      send_command(make_cmd(ACT_SET, 3'd7, 16'(k * 1000), 2'(k)));
    send_command(make_cmd(ACT_SET, 3'd7, 16'd2000, EASE_SINE));
    send_command(make_cmd(ACT_QUERY, 3'd7, 16'd2500, EASE_LIN));

    for (int k = 0; k < 500; k++) begin
      ch = 3'($urandom_range(0, 7));
      r  = $urandom_range(0, 99);
      if (r < 40)      c = make_cmd(ACT_SET, ch, random_frame(ch), 2'($urandom));
      else if (r < 55) c = make_cmd(ACT_DEL, ch, random_frame(ch), 2'($urandom));
      else if (r < 95) c = make_cmd(ACT_QUERY, ch, random_frame(ch), 2'($urandom));
      else             c = make_cmd(ACT_NOP, ch, 16'($urandom), 2'($urandom));
      send_command(c);
    end
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Sent %0d transactions, %0d of them queries, over all eight channels.",
             sent_count, query_count);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
